// ----- rtl/wrsad_pkg.sv -----
// Shared types and constants for the white-run segment anomaly detector.
package wrsad_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 13;
    localparam int COL_W      = 12;
    localparam int SEEN_W     = 7;
    localparam int RATIO_W    = 8;
    localparam int PEAK_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int PROD_W     = RATIO_W + CNT_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_BLACK = 2'd1;
    localparam logic [1:0] CLS_WHITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK    = 2'd2;

    localparam logic [SLOT_W-1:0]  RST_WINDOW_SIZE = 6'd13;
    localparam logic [RATIO_W-1:0] RST_RATIO_LIMIT = 8'd10;
    localparam logic [PEAK_W-1:0]  RST_MIN_PEAK    = 12'd150;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [COL_W-1:0] seg_start;
        logic [COL_W-1:0] seg_end;
    } slot_t;

    typedef struct packed {
        logic load;
        logic row_clr;
        logic trans;
        logic inc;
        logic set_start;
        logic set_end;
        logic snap;
        logic scan_shift;
    } cell_ctl_t;

endpackage

// ----- rtl/wrsad_cell.sv -----
// One window slot: live segment record plus a scan copy, both shifting to the lower neighbor.
module wrsad_cell
    import wrsad_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic             at_new,
    input  logic             below_new,
    input  logic [COL_W-1:0] col,
    input  slot_t            up_mod,
    input  slot_t            up_scan,
    output slot_t            mod,
    output slot_t            scan
);

    slot_t slot_reg, slot_next;
    slot_t scan_reg, scan_next;
    slot_t base;

    always_comb begin
        base = ctl.row_clr ? '0 : slot_reg;
        mod  = base;
        if (at_new) begin
            if (ctl.inc && base.cnt != CNT_MAX) begin
                mod.cnt = base.cnt + CNT_W'(1);
            end
            if (ctl.set_start) begin
                mod.seg_start = col;
            end
            if (ctl.set_end) begin
                mod.seg_end = col;
            end
        end
        slot_next = slot_reg;
        if (ctl.load) begin
            if (ctl.trans && below_new) begin
                slot_next = up_mod;
            end else if (ctl.trans && at_new) begin
                slot_next = '0;
            end else begin
                slot_next = mod;
            end
        end
        scan_next = scan_reg;
        if (ctl.snap) begin
            scan_next = up_mod;
        end else if (ctl.scan_shift) begin
            scan_next = up_scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    assign scan = scan_reg;

endmodule

// ----- rtl/wrsad_rank.sv -----
// Running first-maximum and three smallest distinct counts over the scanned slots.
module wrsad_rank
    import wrsad_pkg::*;
(
    input  logic             aclk,
    input  logic             clear,
    input  logic             step,
    input  slot_t            c,
    output logic [CNT_W-1:0] mx,
    output logic [COL_W-1:0] mx_start,
    output logic [COL_W-1:0] mx_end,
    output logic [CNT_W-1:0] m1,
    output logic [CNT_W-1:0] m2,
    output logic [CNT_W-1:0] m3,
    output logic             h2,
    output logic             h3
);

    logic [CNT_W-1:0] mx_reg, mx_next, m1_reg, m1_next, m2_reg, m2_next, m3_reg, m3_next;
    logic [COL_W-1:0] s_reg, s_next, e_reg, e_next;
    logic             h1_reg, h1_next, h2_reg, h2_next, h3_reg, h3_next;

    always_comb begin
        mx_next = mx_reg;
        s_next  = s_reg;
        e_next  = e_reg;
        m1_next = m1_reg;
        m2_next = m2_reg;
        m3_next = m3_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        h3_next = h3_reg;
        if (clear) begin
            mx_next = '0;
            s_next  = '0;
            e_next  = '0;
            m1_next = '0;
            m2_next = '0;
            m3_next = '0;
            h1_next = 1'b0;
            h2_next = 1'b0;
            h3_next = 1'b0;
        end else if (step) begin
            if (mx_reg < c.cnt) begin
                mx_next = c.cnt;
                s_next  = c.seg_start;
                e_next  = c.seg_end;
            end
            if (!h1_reg || c.cnt < m1_reg) begin
                m3_next = m2_reg;
                h3_next = h2_reg;
                m2_next = m1_reg;
                h2_next = h1_reg;
                m1_next = c.cnt;
                h1_next = 1'b1;
            end else if (c.cnt > m1_reg && (!h2_reg || c.cnt < m2_reg)) begin
                m3_next = m2_reg;
                h3_next = h2_reg;
                m2_next = c.cnt;
                h2_next = 1'b1;
            end else if (h2_reg && c.cnt > m2_reg && (!h3_reg || c.cnt < m3_reg)) begin
                m3_next = c.cnt;
                h3_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mx_reg <= mx_next;
        s_reg  <= s_next;
        e_reg  <= e_next;
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        m3_reg <= m3_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        h3_reg <= h3_next;
    end

    assign mx       = mx_reg;
    assign mx_start = s_reg;
    assign mx_end   = e_reg;
    assign m1       = m1_reg;
    assign m2       = m2_reg;
    assign m3       = m3_reg;
    assign h2       = h2_reg;
    assign h3       = h3_reg;

endmodule

// ----- rtl/white_run_segment_anomaly_detector.sv -----
// A pixel that closes no segment, or arrives before the window is full, does not start a scan.
// A closing transition on a full window scans window_size-1 slots, one per cycle, through the
// scan chain, then applies the ratio test, holding until the result register is free.
// Input: one pixel per cycle while idle; s_ready is low during the scan and the ratio test.
// Reset: aresetn (synchronous, active low) clears the window, history and control state,
// and loads window_size 13, ratio_limit 10, min_peak 150.
module white_run_segment_anomaly_detector
    import wrsad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_pixel,
    input  logic [COL_W-1:0]      s_column,
    input  logic                  s_row_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COL_W-1:0]      m_seg_start,
    output logic [COL_W-1:0]      m_seg_end,
    output logic                  m_is_bad
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    // Configuration registers
    logic [SLOT_W-1:0]  win_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [PEAK_W-1:0]  peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= RST_WINDOW_SIZE;
            ratio_reg <= RST_RATIO_LIMIT;
            peak_reg  <= RST_MIN_PEAK;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WINDOW_SIZE: win_reg   <= cfg_wdata[SLOT_W-1:0];
                REG_RATIO_LIMIT: ratio_reg <= cfg_wdata[RATIO_W-1:0];
                REG_MIN_PEAK:    peak_reg  <= cfg_wdata[PEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // Pixel classification and edge detection
    logic [1:0]        state_reg, state_next;
    logic [1:0]        prev_reg, prev_next, pprev_reg, pprev_next;
    logic [1:0]        cls, p_eff, pp_eff;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_base, seen_inc;
    logic              full_reg, full_next, full_base;
    logic [SLOT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              accept, trans, seg_open, evaluate;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (s_pixel == 8'd0) begin
            cls = CLS_BLACK;
        end else if (s_pixel == 8'd255) begin
            cls = CLS_WHITE;
        end else begin
            cls = CLS_OTHER;
        end
        // A row start primes both history registers with this pixel's class.
        p_eff    = s_row_start ? cls : prev_reg;
        pp_eff   = s_row_start ? cls : pprev_reg;
        seg_open = (cls == CLS_WHITE) && (p_eff == CLS_BLACK) && (pp_eff == CLS_BLACK);
        trans    = (cls == CLS_BLACK) && (p_eff == CLS_WHITE) && (pp_eff == CLS_WHITE);
    end

    // Window fill tracking; evaluation looks at the fill flag from before the transition.
    always_comb begin
        seen_base = s_row_start ? '0 : seen_reg;
        full_base = s_row_start ? 1'b0 : full_reg;
        seen_inc  = (seen_base == SEEN_MAX) ? seen_base : seen_base + SEEN_W'(1);
        evaluate  = accept && trans && full_base && (win_reg >= SLOT_W'(2));
        seen_next = seen_reg;
        full_next = full_reg;
        prev_next = prev_reg;
        pprev_next = pprev_reg;
        if (accept) begin
            prev_next  = cls;
            pprev_next = p_eff;
            seen_next  = seen_base;
            full_next  = full_base;
            if (trans) begin
                seen_next = seen_inc;
                if ({1'b0, seen_inc} + (SEEN_W+1)'(1) >= (SEEN_W+1)'(win_reg)) begin
                    full_next = 1'b1;
                end
            end
        end
    end

    // Chain of slot cells
    cell_ctl_t ctl;
    slot_t     mod_w [SLOTS+1];
    slot_t     scan_w[SLOTS+1];

    assign ctl.load       = accept;
    assign ctl.row_clr    = accept && s_row_start;
    assign ctl.trans      = trans;
    assign ctl.inc        = (cls == CLS_WHITE);
    assign ctl.set_start  = seg_open;
    assign ctl.set_end    = trans;
    assign ctl.snap       = evaluate;
    assign ctl.scan_shift = (state_reg == ST_SCAN);

    assign mod_w[SLOTS]  = '0;
    assign scan_w[SLOTS] = '0;

    // Cell i takes slot i+1 on a shift; the scan copy starts at old slot 1 in cell 0.
    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            slot_t up_mod_i;
            assign up_mod_i = mod_w[gi+1];
            wrsad_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .at_new    (win_reg == SLOT_W'(gi)),
                .below_new (SLOT_W'(gi) < win_reg),
                .col       (s_column),
                .up_mod    (up_mod_i),
                .up_scan   (scan_w[gi+1]),
                .mod       (mod_w[gi]),
                .scan      (scan_w[gi])
            );
        end
    endgenerate

    // Rank accumulator fed from the head of the scan chain
    logic [CNT_W-1:0] mx, m1, m2, m3;
    logic [COL_W-1:0] mx_start, mx_end;
    logic             h2, h3;

    wrsad_rank u_rank (
        .aclk     (aclk),
        .clear    (evaluate),
        .step     (state_reg == ST_SCAN),
        .c        (scan_w[0]),
        .mx       (mx),
        .mx_start (mx_start),
        .mx_end   (mx_end),
        .m1       (m1),
        .m2       (m2),
        .m3       (m3),
        .h2       (h2),
        .h3       (h3)
    );

    // Ratio test and result register
    logic [CNT_W-1:0]  third;
    logic [PROD_W-1:0] prod;
    logic              emit, bad, out_free;
    logic              m_valid_reg, m_valid_next;
    logic [COL_W-1:0]  m_start_reg, m_end_reg;
    logic              m_bad_reg;

    always_comb begin
        if (win_reg <= SLOT_W'(3)) begin
            third = m1;
        end else if (h3) begin
            third = m3;
        end else if (h2) begin
            third = m2;
        end else begin
            third = m1;
        end
        prod     = PROD_W'(ratio_reg) * PROD_W'(third);
        bad      = (PROD_W'(mx) > prod) && (mx > CNT_W'(peak_reg));
        emit     = (mx != '0) && (mx_start != '0) && (mx_end != '0);
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (evaluate) begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN: begin
                // Advance one slot per cycle; the last one is slot window_size-1.
                scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                if (scan_cnt_reg == win_reg - SLOT_W'(2)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // Hold until the result register can take the item.
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (emit) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            prev_reg     <= CLS_OTHER;
            pprev_reg    <= CLS_OTHER;
            seen_reg     <= '0;
            full_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            prev_reg     <= prev_next;
            pprev_reg    <= pprev_next;
            seen_reg     <= seen_next;
            full_reg     <= full_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINAL && out_free && emit) begin
            m_start_reg <= mx_start;
            m_end_reg   <= mx_end;
            m_bad_reg   <= bad;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_seg_start = m_start_reg;
    assign m_seg_end   = m_end_reg;
    assign m_is_bad    = m_bad_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_cnt_reg <= win_reg - SLOT_W'(2))
        else $error("scan count ran past the window");
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input taken while evaluating");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_FINAL)
        else $error("result raised outside final step");
`endif

endmodule
